/* design/ngrp_pkg.sv */
// ---------------------------------------------------------------------------
// ngrp_pkg
// Shared types, constants and helpers of the GGA/RMC sentence field parser.
// ---------------------------------------------------------------------------
package ngrp_pkg;

    localparam int MAX_SENTENCE_BYTES = 128;
    localparam int FRACTION_DIGITS    = 4;
    localparam int BPOS_W             = $clog2(MAX_SENTENCE_BYTES + 1);
    localparam int FRAC_W             = 20;
    localparam int RES_SLOTS          = 4;

    localparam logic [4:0] ZONE_RESET = 5'd8;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;

    localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

    localparam logic [4:0] VID_HOUR      = 5'd0;
    localparam logic [4:0] VID_MIN       = 5'd1;
    localparam logic [4:0] VID_SEC       = 5'd2;
    localparam logic [4:0] VID_CARRY     = 5'd3;
    localparam logic [4:0] VID_LAT_DEG   = 5'd4;
    localparam logic [4:0] VID_LAT_MIN   = 5'd5;
    localparam logic [4:0] VID_LAT_HEMI  = 5'd6;
    localparam logic [4:0] VID_LON_DEG   = 5'd7;
    localparam logic [4:0] VID_LON_MIN   = 5'd8;
    localparam logic [4:0] VID_LON_HEMI  = 5'd9;
    localparam logic [4:0] VID_SATS      = 5'd10;
    localparam logic [4:0] VID_ALT       = 5'd11;
    localparam logic [4:0] VID_GGA_DONE  = 5'd12;
    localparam logic [4:0] VID_SPEED     = 5'd13;
    localparam logic [4:0] VID_COURSE    = 5'd14;
    localparam logic [4:0] VID_DAY       = 5'd15;
    localparam logic [4:0] VID_MONTH     = 5'd16;
    localparam logic [4:0] VID_YEAR      = 5'd17;
    localparam logic [4:0] VID_RMC_DONE  = 5'd18;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_GGA  = 2'd1,
        KIND_RMC  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [4:0]  id;
        logic [31:0] value;
    } t_result;

    typedef struct packed {
        logic [2:0]                  cnt;
        t_result [RES_SLOTS-1:0]     item;
    } t_result_set;

    function automatic logic [FRAC_W-1:0] pow10(input logic [2:0] e);
        logic [FRAC_W-1:0] p;
        unique case (e)
            3'd0:    p = FRAC_W'(1);
            3'd1:    p = FRAC_W'(10);
            3'd2:    p = FRAC_W'(100);
            3'd3:    p = FRAC_W'(1000);
            3'd4:    p = FRAC_W'(10000);
            3'd5:    p = FRAC_W'(100000);
            3'd6:    p = FRAC_W'(1000000);
            default: p = FRAC_W'(1);
        endcase
        return p;
    endfunction

    function automatic logic [4:0] mod24(input logic [7:0] h);
        logic [7:0] v;
        v = h;
        if (v >= 8'd192) v = v - 8'd192;
        if (v >= 8'd96)  v = v - 8'd96;
        if (v >= 8'd48)  v = v - 8'd48;
        if (v >= 8'd24)  v = v - 8'd24;
        return v[4:0];
    endfunction

endpackage

/* design/ngrp_parse.sv */
// ---------------------------------------------------------------------------
// ngrp_parse
// Sentence state, number parsing and per-byte result generation.
// ---------------------------------------------------------------------------
module ngrp_parse import ngrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_byte,
    input  logic        i_end,
    input  logic [4:0]  i_zone,
    output t_result_set o_res
);

    logic [BPOS_W-1:0] r_bpos, n_bpos;
    logic [3:0]        r_commas, n_commas;
    t_kind             r_kind, n_kind;
    logic              r_abort, n_abort;
    logic [6:0]        r_flen, n_flen;
    logic [30:0]       r_int, n_int;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [2:0]        r_fseen, n_fseen;
    logic              r_neg, n_neg;
    logic              r_point, n_point;
    logic              r_stop, n_stop;
    logic [3:0]        r_cap [6];
    logic [3:0]        n_cap [6];
    logic [7:0]        r_first, n_first;
    logic              r_carry, n_carry;

    logic [7:0]  td0, td1, td2, td4;
    logic [10:0] deg3;
    logic [51:0] fix_sum;
    logic [31:0] fix_val, sats_val, hemi_val;
    logic [7:0]  hour_raw;
    logic [7:0]  day, mon;
    logic [11:0] year;
    logic [7:0]  mend;
    logic        leap;
    logic [6:0]  off;
    logic        is_digit;
    logic [34:0] int_next;
    logic [3:0]  dgt;
    t_result_set res;

    always_comb begin
        td0  = 8'({4'd0, r_cap[0]} * 8'd10) + {4'd0, r_cap[1]};
        td1  = 8'({4'd0, r_cap[1]} * 8'd10) + {4'd0, r_cap[2]};
        td2  = 8'({4'd0, r_cap[2]} * 8'd10) + {4'd0, r_cap[3]};
        td4  = 8'({4'd0, r_cap[4]} * 8'd10) + {4'd0, r_cap[5]};
        deg3 = 11'({7'd0, r_cap[0]} * 11'd100) + {3'd0, td1};

        fix_sum = 52'({21'd0, r_int} * 52'(10 ** FRACTION_DIGITS))
                + 52'({32'd0, r_frac} * 52'(pow10(3'(FRACTION_DIGITS) - r_fseen)));
        if (fix_sum > {21'd0, SAT31}) begin
            fix_val = {1'b0, SAT31};
        end else begin
            fix_val = fix_sum[31:0];
        end
        if (r_neg) fix_val = 32'd0 - fix_val;
        sats_val = r_neg ? 32'd0 - {1'b0, r_int} : {1'b0, r_int};
        hemi_val = (r_flen == 7'd0) ? {24'd0, CH_COMMA} : {24'd0, r_first};

        hour_raw = td0 + {3'd0, i_zone};

        day  = td0 + {7'd0, r_carry};
        mon  = td2;
        year = 12'd2000 + {4'd0, td4};
        leap = (td4[1:0] == 2'd0) && (td4 != 8'd100);
        if (mon == 8'd4 || mon == 8'd6 || mon == 8'd9 || mon == 8'd11) begin
            mend = 8'd30;
        end else if (mon == 8'd2) begin
            mend = leap ? 8'd29 : 8'd28;
        end else begin
            mend = 8'd31;
        end
        if (day > mend) begin
            day = 8'd1;
            mon = mon + 8'd1;
            if (mon > 8'd12) begin
                mon  = 8'd1;
                year = year + 12'd1;
            end
        end
    end

    always_comb begin
        n_bpos   = r_bpos;
        n_commas = r_commas;
        n_kind   = r_kind;
        n_abort  = r_abort;
        n_flen   = r_flen;
        n_int    = r_int;
        n_frac   = r_frac;
        n_fseen  = r_fseen;
        n_neg    = r_neg;
        n_point  = r_point;
        n_stop   = r_stop;
        n_cap    = r_cap;
        n_first  = r_first;
        n_carry  = r_carry;
        res      = '0;
        off      = 7'd0;
        is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        dgt      = 4'(i_byte - CH_ZERO);
        int_next = 35'({4'd0, r_int} * 35'd10) + {31'd0, dgt};

        if (r_bpos < BPOS_W'(MAX_SENTENCE_BYTES)) begin
            if (r_bpos == BPOS_W'(3)) begin
                if (r_commas != 4'd0) n_kind = KIND_NONE;
                else if (i_byte == CH_G) n_kind = KIND_GGA;
                else if (i_byte == CH_R) n_kind = KIND_RMC;
                else n_kind = KIND_NONE;
            end else if (r_bpos == BPOS_W'(4)) begin
                if ((r_kind == KIND_GGA && i_byte != CH_G) ||
                    (r_kind == KIND_RMC && i_byte != CH_M)) n_kind = KIND_NONE;
            end else if (r_bpos == BPOS_W'(5)) begin
                if ((r_kind == KIND_GGA && i_byte != CH_A) ||
                    (r_kind == KIND_RMC && i_byte != CH_C)) n_kind = KIND_NONE;
            end

            if (i_byte == 8'd0) begin
                n_abort = 1'b1;
            end else if (i_byte == CH_COMMA) begin
                if (!r_abort && n_kind == KIND_GGA) begin
                    unique case (r_commas)
                        4'd1: begin
                            if (r_flen < 7'd9) begin
                                n_abort = 1'b1;
                            end else begin
                                n_carry = (hour_raw >= 8'd24);
                                res.cnt = 3'd4;
                                res.item[0] = '{VID_HOUR,
                                    {27'd0, (hour_raw >= 8'd24) ? mod24(hour_raw)
                                                                : hour_raw[4:0]}};
                                res.item[1] = '{VID_MIN, {24'd0, td2}};
                                res.item[2] = '{VID_SEC, {24'd0, td4}};
                                res.item[3] = '{VID_CARRY, {31'd0, hour_raw >= 8'd24}};
                            end
                        end
                        4'd2: begin
                            if (r_flen < 7'd8) begin
                                n_abort = 1'b1;
                            end else begin
                                res.cnt = 3'd2;
                                res.item[0] = '{VID_LAT_DEG, {24'd0, td0}};
                                res.item[1] = '{VID_LAT_MIN, fix_val};
                            end
                        end
                        4'd3: begin
                            res.cnt = 3'd1;
                            res.item[0] = '{VID_LAT_HEMI, hemi_val};
                        end
                        4'd4: begin
                            if (r_flen < 7'd9) begin
                                n_abort = 1'b1;
                            end else begin
                                res.cnt = 3'd2;
                                res.item[0] = '{VID_LON_DEG, {21'd0, deg3}};
                                res.item[1] = '{VID_LON_MIN, fix_val};
                            end
                        end
                        4'd5: begin
                            res.cnt = 3'd1;
                            res.item[0] = '{VID_LON_HEMI, hemi_val};
                        end
                        4'd7: begin
                            res.cnt = 3'd1;
                            res.item[0] = '{VID_SATS, sats_val};
                        end
                        4'd9: begin
                            res.cnt = 3'd2;
                            res.item[0] = '{VID_ALT, fix_val};
                            res.item[1] = '{VID_GGA_DONE, 32'd1};
                        end
                        default: begin
                        end
                    endcase
                end else if (!r_abort && n_kind == KIND_RMC) begin
                    unique case (r_commas)
                        4'd7: begin
                            res.cnt = 3'd1;
                            res.item[0] = '{VID_SPEED, fix_val};
                        end
                        4'd8: begin
                            res.cnt = 3'd1;
                            res.item[0] = '{VID_COURSE, fix_val};
                        end
                        4'd9: begin
                            if (r_flen < 7'd6) begin
                                n_abort = 1'b1;
                            end else begin
                                res.cnt = 3'd4;
                                res.item[0] = '{VID_DAY, {24'd0, day}};
                                res.item[1] = '{VID_MONTH, {24'd0, mon}};
                                res.item[2] = '{VID_YEAR, {20'd0, year}};
                                res.item[3] = '{VID_RMC_DONE, 32'd1};
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (r_commas != 4'd15) n_commas = r_commas + 4'd1;
                n_flen  = 7'd0;
                n_int   = '0;
                n_frac  = '0;
                n_fseen = 3'd0;
                n_neg   = 1'b0;
                n_point = 1'b0;
                n_stop  = 1'b0;
                for (int i = 0; i < 6; i++) n_cap[i] = 4'd0;
                n_first = 8'd0;
            end else begin
                if (n_kind == KIND_GGA && r_commas == 4'd2) off = 7'd2;
                else if (n_kind == KIND_GGA && r_commas == 4'd4) off = 7'd3;
                if (r_flen < 7'd6) n_cap[r_flen[2:0]] = dgt;
                if (r_flen == 7'd0) n_first = i_byte;
                if (r_flen >= off && !r_stop) begin
                    if (r_flen == off && (i_byte == CH_MINUS || i_byte == CH_PLUS)) begin
                        n_neg = (i_byte == CH_MINUS);
                    end else if (is_digit) begin
                        if (!r_point) begin
                            n_int = (int_next > {4'd0, SAT31}) ? SAT31 : int_next[30:0];
                        end else if (r_fseen < 3'(FRACTION_DIGITS)) begin
                            n_frac  = FRAC_W'(r_frac * FRAC_W'(10)) + FRAC_W'(dgt);
                            n_fseen = r_fseen + 3'd1;
                        end
                    end else if (i_byte == CH_POINT && !r_point) begin
                        n_point = 1'b1;
                    end else begin
                        n_stop = 1'b1;
                    end
                end
                if (r_flen != 7'd127) n_flen = r_flen + 7'd1;
            end
            n_bpos = r_bpos + BPOS_W'(1);
        end

        if (i_end) begin
            n_bpos   = '0;
            n_commas = 4'd0;
            n_kind   = KIND_NONE;
            n_abort  = 1'b0;
            n_flen   = 7'd0;
            n_int    = '0;
            n_frac   = '0;
            n_fseen  = 3'd0;
            n_neg    = 1'b0;
            n_point  = 1'b0;
            n_stop   = 1'b0;
            for (int i = 0; i < 6; i++) n_cap[i] = 4'd0;
            n_first  = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpos   <= '0;
            r_commas <= 4'd0;
            r_kind   <= KIND_NONE;
            r_abort  <= 1'b0;
            r_flen   <= 7'd0;
            r_int    <= '0;
            r_frac   <= '0;
            r_fseen  <= 3'd0;
            r_neg    <= 1'b0;
            r_point  <= 1'b0;
            r_stop   <= 1'b0;
            for (int i = 0; i < 6; i++) r_cap[i] <= 4'd0;
            r_first  <= 8'd0;
            r_carry  <= 1'b0;
        end else if (i_fire) begin
            r_bpos   <= n_bpos;
            r_commas <= n_commas;
            r_kind   <= n_kind;
            r_abort  <= n_abort;
            r_flen   <= n_flen;
            r_int    <= n_int;
            r_frac   <= n_frac;
            r_fseen  <= n_fseen;
            r_neg    <= n_neg;
            r_point  <= n_point;
            r_stop   <= n_stop;
            r_cap    <= n_cap;
            r_first  <= n_first;
            r_carry  <= n_carry;
        end
    end

    assign o_res = res;

endmodule

/* design/nmea_gga_rmc_field_parser.sv */
// ---------------------------------------------------------------------------
// nmea_gga_rmc_field_parser
// Parses GGA and RMC sentence bytes into time, position and date values.
// ---------------------------------------------------------------------------
// channel  direction  beat
// cfg      in         i_cfg_data[4:0] = zone offset hours
// s        in         tdata[7:0] = rx_byte, tlast = sentence_end
// m        out        tdata[4:0] = value_id, [36:5] = value, tlast = last
//
// One byte a cycle when unstalled: a byte is registered, then parsed into up
// to four results held in a result buffer. Results drain one a cycle while m
// is ready; a byte with several results holds the parse stage until its last
// result drains. Synchronous active-low reset clears sentence state and day
// carry, sets zone offset 8. A stall on m backs up through the buffer to s.
// ---------------------------------------------------------------------------
module nmea_gga_rmc_field_parser import ngrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [4:0] value_id, [36:5] value, [39:37] zero
    output logic        o_m_tlast
);

    logic [4:0]  r_zone;
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_end;
    t_result     r_res [RES_SLOTS];
    logic [2:0]  r_cnt;
    logic [1:0]  r_idx;
    logic        out_hs;
    logic        fire;
    t_result_set res;

    assign o_cfg_ready = 1'b1;
    assign out_hs      = (r_cnt != 3'd0) && i_m_tready;
    assign fire        = r_in_vld && ((r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_m_tready));
    assign o_s_tready  = !r_in_vld || fire;

    ngrp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .i_zone  (r_zone),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ZONE_RESET;
        end else if (i_cfg_valid) begin
            r_zone <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_end  <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_idx <= 2'd0;
        end else if (fire) begin
            r_cnt <= res.cnt;
            r_idx <= 2'd0;
        end else if (out_hs) begin
            r_cnt <= r_cnt - 3'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            for (int i = 0; i < RES_SLOTS; i++) r_res[i] <= res.item[i];
        end
    end

    assign o_m_tvalid = (r_cnt != 3'd0);
    assign o_m_tdata  = {3'd0, r_res[r_idx].value, r_res[r_idx].id};
    assign o_m_tlast  = (r_cnt == 3'd1);

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the GGA/RMC sentence field parser: directed and
// random sentence bytes are fed on the s stream, a local sentence model
// predicts every result beat, and the m stream is compared in order.
// ---------------------------------------------------------------------------
module tb import ngrp_pkg::*; ();

    localparam int LIMIT = 400000;
    localparam int ITEMS = 410;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic        o_m_tlast;

    nmea_gga_rmc_field_parser DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    typedef struct {
        logic [4:0]  id;
        logic [31:0] value;
        logic        last;
    } t_beat;

    t_beat  pending_q[$];
    int     errors = 0;
    int     cycles = 0;
    int     sent = 0;
    int     rx_gap = 0;
    bit     hold_off = 1'b0;

    // sentence model state
    logic [4:0]  zone;
    int unsigned bpos, commas, fld_len, ipart, fpart, fdig, first_ch, carry;
    t_kind       kind;
    bit          abort_s, neg, point, stopped;
    int unsigned caps[6];
    t_beat       step_out[$];

    function automatic void clear_field();
        fld_len = 0; ipart = 0; fpart = 0; fdig = 0;
        neg = 0; point = 0; stopped = 0; first_ch = 0;
        foreach (caps[i]) caps[i] = 0;
    endfunction

    function automatic void clear_sentence();
        bpos = 0; commas = 0; kind = KIND_NONE; abort_s = 0;
        clear_field();
    endfunction

    function automatic void add(logic [4:0] id, logic [31:0] v);
        t_beat b;
        b.id = id; b.value = v; b.last = 0;
        step_out.push_back(b);
    endfunction

    function automatic logic [31:0] apply_sign(longint unsigned mag);
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return neg ? 32'(-mag) : 32'(mag);
    endfunction

    function automatic logic [31:0] fixed_val();
        longint unsigned p, v;
        p = 1;
        for (int i = fdig; i < FRACTION_DIGITS; i++) p = p * 10;
        v = longint'(ipart) * 10000 + longint'(fpart) * p;
        return apply_sign(v);
    endfunction

    function automatic int unsigned pair(int i);
        return caps[i] * 10 + caps[i+1];
    endfunction

    function automatic int unsigned days_in(int unsigned m, int unsigned y);
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        if (m == 2) return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
        return 31;
    endfunction

    function automatic logic [31:0] hemi();
        return fld_len == 0 ? 32'(CH_COMMA) : 32'(first_ch);
    endfunction

    function automatic void close_field();
        int unsigned h, d, m, y;
        if (abort_s || kind == KIND_NONE) return;
        if (kind == KIND_GGA) begin
            case (commas)
                1: begin
                    if (fld_len < 9) begin abort_s = 1; return; end
                    h = pair(0) + zone;
                    if (h >= 24) begin h = h % 24; carry = 1; end else carry = 0;
                    add(VID_HOUR, h); add(VID_MIN, pair(2));
                    add(VID_SEC, pair(4)); add(VID_CARRY, carry);
                end
                2: begin
                    if (fld_len < 8) begin abort_s = 1; return; end
                    add(VID_LAT_DEG, pair(0)); add(VID_LAT_MIN, fixed_val());
                end
                3: add(VID_LAT_HEMI, hemi());
                4: begin
                    if (fld_len < 9) begin abort_s = 1; return; end
                    add(VID_LON_DEG, caps[0] * 100 + pair(1));
                    add(VID_LON_MIN, fixed_val());
                end
                5: add(VID_LON_HEMI, hemi());
                7: add(VID_SATS, apply_sign(ipart));
                9: begin add(VID_ALT, fixed_val()); add(VID_GGA_DONE, 1); end
                default: ;
            endcase
        end else if (kind == KIND_RMC) begin
            case (commas)
                7: add(VID_SPEED, fixed_val());
                8: add(VID_COURSE, fixed_val());
                9: begin
                    if (fld_len < 6) begin abort_s = 1; return; end
                    d = pair(0) + carry; m = pair(2); y = 2000 + pair(4);
                    if (d > days_in(m, y)) begin
                        d = 1; m++;
                        if (m > 12) begin m = 1; y++; end
                    end
                    add(VID_DAY, d); add(VID_MONTH, m); add(VID_YEAR, y);
                    add(VID_RMC_DONE, 1);
                end
                default: ;
            endcase
        end
    endfunction

    function automatic void feed(int unsigned b, bit first);
        if (stopped) return;
        if (first && (b == CH_MINUS || b == CH_PLUS)) begin neg = (b == CH_MINUS); return; end
        if (b >= CH_ZERO && b <= CH_NINE) begin
            if (!point) begin
                longint unsigned v;
                v = longint'(ipart) * 10 + (b - 48);
                ipart = v > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : int'(v);
            end else if (fdig < FRACTION_DIGITS) begin
                fpart = fpart * 10 + (b - 48); fdig++;
            end
            return;
        end
        if (b == CH_POINT && !point) begin point = 1; return; end
        stopped = 1;
    endfunction

    // predict the result beats of one accepted byte and queue them
    function automatic void predict_byte(logic [7:0] ch, logic eos);
        int unsigned off;
        step_out.delete();
        if (bpos < MAX_SENTENCE_BYTES) begin
            if (bpos == 3) kind = (commas != 0) ? KIND_NONE :
                (ch == CH_G) ? KIND_GGA : (ch == CH_R) ? KIND_RMC : KIND_NONE;
            else if (bpos == 4) begin
                if ((kind == KIND_GGA && ch != CH_G) || (kind == KIND_RMC && ch != CH_M))
                    kind = KIND_NONE;
            end else if (bpos == 5) begin
                if ((kind == KIND_GGA && ch != CH_A) || (kind == KIND_RMC && ch != CH_C))
                    kind = KIND_NONE;
            end
            if (ch == 0) abort_s = 1;
            else if (ch == CH_COMMA) begin
                close_field();
                if (commas < 15) commas++;
                clear_field();
            end else begin
                off = (kind == KIND_GGA && commas == 2) ? 2 :
                      (kind == KIND_GGA && commas == 4) ? 3 : 0;
                if (fld_len < 6) caps[fld_len] = (ch - 8'h30) & 4'hF;
                if (fld_len == 0) first_ch = ch;
                if (fld_len >= off) feed(ch, fld_len == off);
                if (fld_len < 127) fld_len++;
            end
            bpos++;
        end
        if (eos) clear_sentence();
        if (step_out.size() > 0) step_out[$].last = 1;
        foreach (step_out[i]) pending_q.push_back(step_out[i]);
    endfunction

    // stimulus byte queue built sentence by sentence
    typedef struct { logic [7:0] ch; logic eos; } t_byte;
    t_byte feed_q[$];

    // directed row: text, then an optional zero byte, then pad commas
    typedef struct {
        string txt;
        bit    zero_byte;
        int    pad;
        bit    eos;
    } t_row;

    t_row dir_tab [13] = '{
        '{"$GPGGA,235959.00,", 1'b0, 0, 1'b0},
        '{"4807.038,,01131.000,W,1,99999999999,0.9,-545.4,M,", 1'b0, 0, 1'b1},
        '{"$GPRMC,,A,,N,,E,+0.5,,280224,,,A", 1'b0, 0, 1'b1},
        '{"$GPGGA,200000.00,", 1'b0, 0, 1'b1},
        '{"$GPRMC,1,2,3,4,5,6,.12345,-1.,311299,", 1'b0, 0, 1'b1},
        '{"$GPRMC,,,,,,,,,3113ab,", 1'b0, 0, 1'b1},
        '{"$GPGGA,12345,1,", 1'b0, 0, 1'b1},
        '{"$GP,GA,123456789,", 1'b0, 0, 1'b1},
        '{"$GPGGA,1", 1'b1, 0, 1'b0},
        '{"23456.00,", 1'b0, 0, 1'b1},
        '{"$GPRMC,,,,,,,,,1201", 1'b0, 0, 1'b1},
        '{"$GPGGA", 1'b0, 125, 1'b1},
        '{"$GPGGA,\3775:5;5<5=5.0,", 1'b0, 0, 1'b1}
    };

    function automatic void push_str(string s, bit eos_at_end);
        t_byte b;
        for (int i = 0; i < s.len(); i++) begin
            b.ch = s[i]; b.eos = eos_at_end && (i == s.len() - 1);
            feed_q.push_back(b);
        end
    endfunction

    function automatic void push_row(t_row r);
        t_byte b;
        push_str(r.txt, r.eos && !r.zero_byte && (r.pad == 0));
        if (r.zero_byte) begin
            b.ch = 8'h00; b.eos = r.eos && (r.pad == 0);
            feed_q.push_back(b);
        end
        for (int i = 0; i < r.pad; i++) begin
            b.ch = CH_COMMA; b.eos = r.eos && (i == r.pad - 1);
            feed_q.push_back(b);
        end
    endfunction

    function automatic string rnd_num(int digits);
        string s;
        s = "";
        for (int i = 0; i < digits; i++) s = {s, string'(8'(48 + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string rnd_field();
        case ($urandom_range(0, 5))
            0: return "";
            1: return rnd_num($urandom_range(1, 12));
            2: return {($urandom_range(0, 1) ? "-" : "+"), rnd_num($urandom_range(0, 5)), ".",
                       rnd_num($urandom_range(0, 7))};
            3: return {rnd_num($urandom_range(0, 4)), ".", rnd_num($urandom_range(0, 6)), "x"};
            4: return string'(8'($urandom_range(1, 255)));
            default: return {rnd_num(3), ".", rnd_num(3)};
        endcase
    endfunction

    function automatic void rnd_sentence();
        string s;
        int r;
        int n;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            s = {"$GPGGA,", rnd_num(2 + $urandom_range(0, 1) * 0), rnd_num(4), ".",
                 rnd_num($urandom_range(1, 3)), ",", rnd_num(4), ".", rnd_num($urandom_range(2, 6)),
                 ",", ($urandom_range(0, 3) ? "N" : ""), ",", rnd_num(5), ".", rnd_num(4), ",",
                 ($urandom_range(0, 1) ? "E" : "W"), ",1,", rnd_num($urandom_range(0, 3)),
                 ",0.9,", rnd_field(), ",M,"};
            if ($urandom_range(0, 5) == 0) s = s.substr(0, $urandom_range(8, s.len() - 1));
        end else if (r < 8) begin
            s = {"$GPRMC,", rnd_num(6), ".00,A,", rnd_num(4), ".", rnd_num(4), ",N,",
                 rnd_num(5), ".", rnd_num(4), ",E,", rnd_field(), ",", rnd_field(), ",",
                 string'(8'(48 + $urandom_range(0, 3))), rnd_num(1),
                 string'(8'(48 + $urandom_range(0, 1))), rnd_num(1), rnd_num(2), ",,,A*"};
        end else begin
            s = "";
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
                s = {s, string'(8'($urandom_range(1, 255)))};
        end
        push_str(s, 1);
    endfunction

    // typed time results of the first directed sentence
    t_beat fixed_exp[$];

    task automatic cfg_write(logic [4:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1; i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        zone = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_all();
        t_byte b;
        int    gap;
        @(negedge i_clk);
        while (feed_q.size() != 0) begin
            b = feed_q.pop_front();
            gap = 0;
            if ($urandom_range(0, 3) == 0)
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_s_tvalid <= 1'b1; i_s_tdata <= b.ch; i_s_tlast <= b.eos;
            do @(posedge i_clk); while (!o_s_tready);
            predict_byte(b.ch, b.eos);
            sent++;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b0;
    endtask

    // receiver with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (hold_off) i_m_tready <= 1'b0;
        else if (rx_gap > 0) begin
            i_m_tready <= 1'b0;
            rx_gap--;
        end else if ($urandom_range(0, 31) == 0) begin
            i_m_tready <= 1'b0;
            rx_gap = $urandom_range(5, 25);
        end
        else i_m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        t_beat e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_q.size() == 0) begin
                $error("result beat with nothing expected: id %0d", o_m_tdata[4:0]);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_m_tdata[4:0] !== e.id) begin
                    $error("value_id: expected %0d, got %0d", e.id, o_m_tdata[4:0]); errors++;
                end
                if (o_m_tdata[36:5] !== e.value) begin
                    $error("value: expected %0d, got %0d", $signed(e.value),
                           $signed(o_m_tdata[36:5])); errors++;
                end
                if (o_m_tlast !== e.last) begin
                    $error("last: expected %0b, got %0b", e.last, o_m_tlast); errors++;
                end
                if (fixed_exp.size() != 0) begin
                    e = fixed_exp.pop_front();
                    if (o_m_tdata[4:0] !== e.id || o_m_tdata[36:5] !== e.value) begin
                        $error("value_id/value: expected %0d/%0d, got %0d/%0d", e.id, e.value,
                               o_m_tdata[4:0], o_m_tdata[36:5]); errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("** nmea_gga_rmc_field_parser: FAILED **");
            $finish;
        end
    end

    initial begin
        t_beat e;
        zone = ZONE_RESET; carry = 0;
        clear_sentence();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // time 23:59:59 at reset offset 8 wraps to 7 with carry
        e.last = 0;
        e.id = VID_HOUR;  e.value = 7;  fixed_exp.push_back(e);
        e.id = VID_MIN;   e.value = 59; fixed_exp.push_back(e);
        e.id = VID_SEC;   e.value = 59; fixed_exp.push_back(e);
        e.id = VID_CARRY; e.value = 1;  fixed_exp.push_back(e);
        foreach (dir_tab[i]) push_row(dir_tab[i]);

        // long hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            send_all();
        join
        drain();

        while (sent < ITEMS) begin
            cfg_write(5'($urandom_range(0, 31)));
            rnd_sentence();
            send_all();
            drain();
        end

        if (errors == 0 && fixed_exp.size() == 0 && pending_q.size() == 0) begin
            $display("** nmea_gga_rmc_field_parser: PASSED **");
        end else begin
            $display("** nmea_gga_rmc_field_parser: FAILED **");
        end
        $finish;
    end
endmodule

/* filelist.f */
design/ngrp_pkg.sv
design/ngrp_parse.sv
design/nmea_gga_rmc_field_parser.sv
tb/sv/tb.sv
